// ===== design/fwq_pkg.sv =====
package fwq_pkg;

  localparam int AddrW  = 64;
  localparam int WordW  = 32;
  localparam int PidW   = 4;
  localparam int TotW   = 5;
  localparam int MaxRes = 16;

  localparam logic [63:0] MultReset = 64'h9E3779B97F4A7C15;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_NO_PROC  = 2'd2,
    ST_WAKE     = 2'd3
  } status_t;

  typedef enum logic {
    CMD_WAIT = 1'b0,
    CMD_WAKE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              command;
    logic [AddrW-1:0]  address;
    logic [PidW-1:0]   caller_pid;
    logic              caller_present;
    logic signed [WordW-1:0] word_now;
    logic signed [WordW-1:0] expected_value;
    logic signed [WordW-1:0] wake_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             woken_valid;
    logic [PidW-1:0]  woken_pid;
    logic [TotW-1:0]  woken_total;
    logic             last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic hash1;
    logic mul0;
    logic mul1;
    logic mul2;
    logic hash3;
    logic mod_step;
    logic wait_exec;
    logic wake_init;
    logic walk_read;
    logic walk_step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_wake;
    logic mod_more;
    logic walk_more;
    logic hit;
    logic held;
  } dp_stat_t;

endpackage

// ===== design/fwq_if.sv =====
interface fwq_in_if;
  import fwq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fwq_out_if;
  import fwq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/fwq_ctrl.sv =====
module fwq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              res_push,
  input  logic              res_full,
  output fwq_pkg::dp_cmd_t  cmd,
  input  fwq_pkg::dp_stat_t stat
);
  import fwq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_H1    = 11'b00000000010,
    S_M0    = 11'b00000000100,
    S_M1    = 11'b00000001000,
    S_M2    = 11'b00000010000,
    S_H3    = 11'b00000100000,
    S_MOD   = 11'b00001000000,
    S_EXEC  = 11'b00010000000,
    S_READ  = 11'b00100000000,
    S_STEP  = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_H1;
        end
      end
      S_H1: begin
        cmd.hash1 = 1'b1;
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_H3;
      end
      S_H3: begin
        cmd.hash3 = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (stat.mod_more) cmd.mod_step = 1'b1;
        else state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.is_wake) begin
          if (!res_full) begin
            cmd.wait_exec = 1'b1;
            res_push      = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.wake_init = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        if (!stat.walk_more) state_nxt = S_FIN;
        else begin
          cmd.walk_read = 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_STEP: begin
        if (!(stat.hit && stat.held && res_full)) begin
          cmd.walk_step = 1'b1;
          res_push      = stat.hit && stat.held;
          state_nxt     = S_READ;
        end
      end
      S_FIN: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/fwq_dp.sv =====
module fwq_dp #(
  parameter int PROCS   = 16,
  parameter int BUCKETS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  input  fwq_pkg::in_item_t  in_data,
  input  fwq_pkg::dp_cmd_t   cmd,
  output fwq_pkg::dp_stat_t  stat,
  input  logic               fin,
  output fwq_pkg::out_item_t res
);
  import fwq_pkg::*;

  localparam int PW = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int LW = PW + 1;
  localparam int MW = BW + 4;
  localparam bit BPOW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  logic [63:0] mult_r;
  in_item_t    item_r;
  logic [63:0] h_r;
  logic [63:0] acc_r;
  logic [BW-1:0] bkt_r;
  logic [4:0]    mcnt_r;

  logic [LW-1:0] head_r [BUCKETS];
  logic [LW-1:0] tail_r [BUCKETS];
  logic [BUCKETS-1:0] bvalid_r;
  logic [LW-1:0] next_r [PROCS];
  logic [63:0]   waddr_r [PROCS];
  logic [PROCS-1:0] blk_r;

  logic [LW-1:0] cur_r, prev_r, nxt_r;
  logic [TotW-1:0] woken_r, limit_r;
  logic [PW:0]     steps_r;
  logic            hit_r;
  logic            hold_v_r;
  logic [PidW-1:0] hold_pid_r;
  logic [TotW-1:0] hold_tot_r;

  logic [LW-1:0] hd, tl;
  logic [63:0]   w0, hf;
  logic [31:0]   op_a, op_b;
  logic [63:0]   prod;
  logic [MW-1:0] mt;
  logic          pid_ok, no_proc;
  logic [PW-1:0] pid_ix, cur_ix, prev_ix;

  assign w0     = {2'b00, item_r.address[63:2]};
  assign hf     = h_r ^ (h_r >> 13);
  assign op_a   = cmd.mul1 ? h_r[63:32] : h_r[31:0];
  assign op_b   = cmd.mul2 ? mult_r[63:32] : mult_r[31:0];
  assign prod   = op_a * op_b;
  assign hd     = bvalid_r[bkt_r] ? head_r[bkt_r] : LW'(PROCS);
  assign tl     = bvalid_r[bkt_r] ? tail_r[bkt_r] : LW'(PROCS);
  assign pid_ok = {1'b0, item_r.caller_pid} < (PidW+1)'(PROCS);
  assign pid_ix = PW'(item_r.caller_pid);
  assign no_proc = !item_r.caller_present || !pid_ok || blk_r[pid_ix];
  assign cur_ix  = cur_r[PW-1:0];
  assign prev_ix = prev_r[PW-1:0];

  // one 4-bit digit of the bucket remainder
  always_comb begin
    mt = {bkt_r, h_r[63:60]};
    for (int k = 3; k >= 0; k--) begin
      if (mt >= (MW'(BUCKETS) << k)) mt = mt - (MW'(BUCKETS) << k);
    end
  end

  assign stat.is_wake   = item_r.command == CMD_WAKE;
  assign stat.mod_more  = mcnt_r != 5'd0;
  assign stat.walk_more = (cur_r < LW'(PROCS)) && (woken_r < limit_r)
                          && (steps_r < (PW+1)'(PROCS));
  assign stat.hit       = hit_r;
  assign stat.held      = hold_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mult_r <= MultReset;
    else if (cfg_we) mult_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.hash1) h_r <= w0 ^ (w0 >> 16);
    else if (cmd.mul2) h_r <= acc_r + {prod[31:0], 32'h0};
    else if (cmd.hash3 && !BPOW2) h_r <= hf;
    else if (cmd.mod_step) h_r <= h_r << 4;
    if (cmd.mul0) acc_r <= prod;
    else if (cmd.mul1) acc_r <= acc_r + {prod[31:0], 32'h0};
    if (cmd.hash3) begin
      bkt_r  <= BPOW2 ? BW'(hf & 64'(BUCKETS - 1)) : '0;
      mcnt_r <= BPOW2 ? 5'd0 : 5'd16;
    end else if (cmd.mod_step) begin
      bkt_r  <= mt[BW-1:0];
      mcnt_r <= mcnt_r - 1'b1;
    end
    if (cmd.walk_read) begin
      nxt_r <= next_r[cur_ix];
      hit_r <= (waddr_r[cur_ix] == item_r.address) && blk_r[cur_ix];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= '0;
      blk_r    <= '0;
    end else if (cmd.wait_exec) begin
      if (!no_proc && item_r.word_now == item_r.expected_value) begin
        blk_r[pid_ix]   <= 1'b1;
        next_r[pid_ix]  <= LW'(PROCS);
        waddr_r[pid_ix] <= item_r.address;
        if (hd >= LW'(PROCS) || tl >= LW'(PROCS)) head_r[bkt_r] <= LW'(pid_ix);
        else next_r[tl[PW-1:0]] <= LW'(pid_ix);
        tail_r[bkt_r]   <= LW'(pid_ix);
        if (!bvalid_r[bkt_r]) begin
          bvalid_r[bkt_r] <= 1'b1;
          head_r[bkt_r]   <= LW'(pid_ix);
        end
      end
    end else if (cmd.walk_step && hit_r) begin
      if (prev_r >= LW'(PROCS)) head_r[bkt_r] <= nxt_r;
      else next_r[prev_ix] <= nxt_r;
      if (tl == cur_r) tail_r[bkt_r] <= prev_r;
      next_r[cur_ix]  <= LW'(PROCS);
      waddr_r[cur_ix] <= '0;
      blk_r[cur_ix]   <= 1'b0;
    end
  end

  logic [TotW-1:0] tot1;
  assign tot1 = woken_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.wake_init) begin
      cur_r    <= hd;
      prev_r   <= LW'(PROCS);
      woken_r  <= '0;
      steps_r  <= '0;
      hold_v_r <= 1'b0;
      if (item_r.wake_limit <= 0) limit_r <= '0;
      else if (item_r.wake_limit > MaxRes) limit_r <= TotW'(MaxRes);
      else limit_r <= TotW'(item_r.wake_limit);
    end else if (cmd.walk_step) begin
      steps_r <= steps_r + 1'b1;
      cur_r   <= nxt_r;
      if (hit_r) begin
        woken_r    <= tot1;
        hold_v_r   <= 1'b1;
        hold_pid_r <= PidW'(cur_r);
        hold_tot_r <= tot1;
      end else begin
        prev_r <= cur_r;
      end
    end
  end

  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (cmd.wait_exec) begin
      if (no_proc) res.status = ST_NO_PROC;
      else if (item_r.word_now != item_r.expected_value) res.status = ST_MISMATCH;
      else res.status = ST_ENQUEUED;
    end else begin
      res.status = ST_WAKE;
      if (!fin || hold_v_r) begin
        res.woken_valid = 1'b1;
        res.woken_pid   = hold_pid_r;
        res.woken_total = hold_tot_r;
      end
      if (!fin) res.last = 1'b0;
    end
  end

endmodule

// ===== design/futex_wait_queue_engine.sv =====
// Hashed futex wait queues. Every item starts with the address hash: a shift and xor step,
// three steps on one 32 by 32 multiplier building the low 64 bits of the product, a second
// shift and xor step and a state to settle the bucket, plus 16 steps of 4-bit remainder when
// BUCKETS is not a power of two. A wait then ends in one more state with one transfer. A wake
// sets up the walk, passes a read and a step state for each queue entry it visits (at most
// PROCS, stopping once wake_limit, clamped to 0..16, processes are woken) and then finishes.
// Each woken process gives one transfer, held back one step so that the final one carries
// last; a wake that wakes nobody ends with one empty report. A full result register holds the
// walk where it is. One item is in work at a time; the result register lets the last transfer
// wait while the next item is taken. The user must write the multiplier register through
// cfg_we/cfg_wdata only while nothing is in flight; the block itself does not enforce this.
module futex_wait_queue_engine #(
  parameter int PROCS   = 16,
  parameter int BUCKETS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  fwq_in_if.sink      in_ch,
  fwq_out_if.source   out_ch
);
  import fwq_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t res;
  logic      res_push, res_full, fin;
  logic      ov_r;
  out_item_t od_r;

  assign res_full = ov_r && !out_ch.ready;
  assign fin = res_push && !cmd.wait_exec && !cmd.walk_step;

  fwq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .res_push(res_push), .res_full(res_full), .cmd(cmd), .stat(stat)
  );

  fwq_dp #(.PROCS(PROCS), .BUCKETS(BUCKETS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_data(in_ch.data), .cmd(cmd), .stat(stat), .fin(fin), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_push) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_push) od_r <= res;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result overrun");
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wait_exec |-> res.last) else $error("wait result not last");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("double accept");

endmodule
